// ----- design/bounded_deque_engine_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the bounded deque engine
// Concurrent checks that can be compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_ENGINE_MACROS_SVH
`define BOUNDED_DEQUE_ENGINE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define BDE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("Implication check failed.");

`define BDE_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("Forbidden condition observed.");

`else

`define BDE_ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`define BDE_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ----- design/bde_pkg.sv -----
// ----------------------------------------------------------------------------
// Bounded deque engine package
// Command and status codes, sequencer states and the beat tag type.
// ----------------------------------------------------------------------------
package bde_pkg;

	typedef enum logic [2:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_POP_FRONT  = 3'd1,
		CMD_PUSH_BACK  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_DUMP       = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		SEQ_RUN,
		SEQ_DUMP
	} seq_state_t;

	typedef struct packed {
		logic    valid;
		status_t status;
		logic    has_word;
		logic    last;
	} bde_tag_t;

endpackage

// ----- design/bde_cmd_if.sv -----
// ----------------------------------------------------------------------------
// Command channel
// Carries one command and its push value per beat.
// ----------------------------------------------------------------------------
interface bde_cmd_if #(
	parameter int DATA_WIDTH = 32
);
	logic                         valid;
	logic                         ready;
	logic [2:0]                   command;
	logic signed [DATA_WIDTH-1:0] value;

	modport source (output valid, output command, output value, input ready);
	modport sink (input valid, input command, input value, output ready);
endinterface

// ----- design/bde_res_if.sv -----
// ----------------------------------------------------------------------------
// Result channel
// Carries status, word, occupancy count and the last flag per beat.
// ----------------------------------------------------------------------------
interface bde_res_if #(
	parameter int DATA_WIDTH = 32,
	parameter int COUNT_WIDTH = 5
);
	logic                         valid;
	logic                         ready;
	logic [1:0]                   status;
	logic signed [DATA_WIDTH-1:0] word;
	logic [COUNT_WIDTH-1:0]       count;
	logic                         last;

	modport source (output valid, output status, output word, output count, output last,
		input ready);
	modport sink (input valid, input status, input word, input count, input last,
		output ready);
endinterface

// ----- design/bde_ram.sv -----
// ----------------------------------------------------------------------------
// Deque store
// Single write port and single read port with registered read data.
// ----------------------------------------------------------------------------
module bde_ram #(
	parameter int DEPTH = 16,
	parameter int DATA_WIDTH = 32,
	localparam int PW = $clog2(DEPTH)
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [PW-1:0]                waddr,
	input  logic signed [DATA_WIDTH-1:0] wdata,
	input  logic                         re,
	input  logic [PW-1:0]                raddr,
	output logic signed [DATA_WIDTH-1:0] rdata
);

	logic signed [DATA_WIDTH-1:0] mem [DEPTH];
	logic signed [DATA_WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- design/bde_ctrl.sv -----
// ----------------------------------------------------------------------------
// Deque controller
// Takes commands, keeps the front pointer and occupancy, drives the store
// and walks the store one entry per cycle for a dump while load_ready is high.
// ----------------------------------------------------------------------------
module bde_ctrl import bde_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int DATA_WIDTH = 32,
	localparam int PW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1),
	localparam int SW = PW + 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	bde_cmd_if.sink                      cmd,
	input  logic                         load_ready,
	output bde_tag_t                     tag,
	output logic [CW-1:0]                tag_count,
	output logic                         we,
	output logic [PW-1:0]                waddr,
	output logic signed [DATA_WIDTH-1:0] wdata,
	output logic                         re,
	output logic [PW-1:0]                raddr
);

	seq_state_t    state_q, state_d;
	logic [PW-1:0] fp_q, fp_d;
	logic [CW-1:0] occ_q, occ_d;
	logic [PW-1:0] idx_q, idx_d;
	logic          accept;
	logic          full;
	logic          empty;
	logic          dump_last;
	logic [PW-1:0] fp_inc;
	logic [PW-1:0] fp_dec;
	logic [PW-1:0] back_pos;
	logic [PW-1:0] back_last;
	logic [PW-1:0] dump_pos;

	function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] base,
		input logic [CW-1:0] off);
		logic [SW-1:0] sum;
		sum = SW'(base) + SW'(off);
		if (sum >= SW'(DEPTH)) begin
			sum = sum - SW'(DEPTH);
		end
		return sum[PW-1:0];
	endfunction

	assign full      = (occ_q == CW'(DEPTH));
	assign empty     = (occ_q == '0);
	assign fp_inc    = (fp_q == PW'(DEPTH - 1)) ? '0 : fp_q + PW'(1);
	assign fp_dec    = (fp_q == '0) ? PW'(DEPTH - 1) : fp_q - PW'(1);
	assign back_pos  = wrap_add(fp_q, occ_q);
	assign back_last = wrap_add(fp_q, occ_q - CW'(1));
	assign dump_pos  = wrap_add(fp_q, CW'(idx_q));
	assign dump_last = (CW'(idx_q) == occ_q - CW'(1));

	assign cmd.ready = (state_q == SEQ_RUN) && load_ready;
	assign accept    = cmd.valid && cmd.ready;
	assign wdata     = cmd.value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_RUN;
			fp_q    <= '0;
			occ_q   <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			fp_q    <= fp_d;
			occ_q   <= occ_d;
			idx_q   <= idx_d;
		end
	end

	always_comb begin
		state_d = state_q;
		fp_d    = fp_q;
		occ_d   = occ_q;
		idx_d   = idx_q;
		we      = 1'b0;
		waddr   = '0;
		re      = 1'b0;
		raddr   = '0;
		tag     = '0;
		case (state_q)
			SEQ_RUN: begin
				if (accept) begin
					tag.valid  = 1'b1;
					tag.last   = 1'b1;
					tag.status = ST_OK;
					case (cmd.command)
						CMD_PUSH_FRONT: begin
							if (full) begin
								tag.status = ST_FULL;
							end else begin
								we    = 1'b1;
								waddr = fp_dec;
								fp_d  = fp_dec;
								occ_d = occ_q + CW'(1);
							end
						end
						CMD_POP_FRONT: begin
							if (empty) begin
								tag.status = ST_EMPTY;
							end else begin
								re           = 1'b1;
								raddr        = fp_q;
								tag.has_word = 1'b1;
								fp_d         = fp_inc;
								occ_d        = occ_q - CW'(1);
							end
						end
						CMD_PUSH_BACK: begin
							if (full) begin
								tag.status = ST_FULL;
							end else begin
								we    = 1'b1;
								waddr = back_pos;
								occ_d = occ_q + CW'(1);
							end
						end
						CMD_POP_BACK: begin
							if (empty) begin
								tag.status = ST_EMPTY;
							end else begin
								re           = 1'b1;
								raddr        = back_last;
								tag.has_word = 1'b1;
								occ_d        = occ_q - CW'(1);
							end
						end
						CMD_DUMP: begin
							if (empty) begin
								tag.status = ST_EMPTY;
							end else begin
								re           = 1'b1;
								raddr        = fp_q;
								tag.has_word = 1'b1;
								tag.last     = (occ_q == CW'(1));
								if (occ_q != CW'(1)) begin
									state_d = SEQ_DUMP;
									idx_d   = PW'(1);
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
			SEQ_DUMP: begin
				if (load_ready) begin
					re           = 1'b1;
					raddr        = dump_pos;
					tag.valid    = 1'b1;
					tag.status   = ST_OK;
					tag.has_word = 1'b1;
					tag.last     = dump_last;
					idx_d        = idx_q + PW'(1);
					if (dump_last) begin
						state_d = SEQ_RUN;
					end
				end
			end
			default: begin
				state_d = SEQ_RUN;
			end
		endcase
		tag_count = occ_d;
	end

endmodule

// ----- design/bde_outq.sv -----
// ----------------------------------------------------------------------------
// Result stage
// Pairs each issued beat with the registered store read data and holds
// finished results in an output register.
// ----------------------------------------------------------------------------
module bde_outq import bde_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int DATA_WIDTH = 32,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bde_tag_t                     tag,
	input  logic [CW-1:0]                tag_count,
	input  logic signed [DATA_WIDTH-1:0] rdata,
	output logic                         load_ready,
	bde_res_if.source                    res
);

	logic                         valid_s1;
	status_t                      status_s1;
	logic                         has_word_s1;
	logic                         last_s1;
	logic [CW-1:0]                count_s1;
	logic                         out_valid_q;
	status_t                      status_q;
	logic signed [DATA_WIDTH-1:0] word_q;
	logic [CW-1:0]                count_q;
	logic                         last_q;
	logic                         out_free;
	logic                         adv;

	assign out_free   = !out_valid_q || res.ready;
	assign adv        = valid_s1 && out_free;
	assign load_ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_ready) begin
				valid_s1 <= tag.valid;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tag.valid && load_ready) begin
			status_s1   <= tag.status;
			has_word_s1 <= tag.has_word;
			last_s1     <= tag.last;
			count_s1    <= tag_count;
		end
		if (adv) begin
			status_q <= status_s1;
			word_q   <= has_word_s1 ? rdata : '0;
			count_q  <= count_s1;
			last_q   <= last_s1;
		end
	end

	assign res.valid  = out_valid_q;
	assign res.status = status_q;
	assign res.word   = word_q;
	assign res.count  = count_q;
	assign res.last   = last_q;

endmodule

// ----- design/bounded_deque_engine.sv -----
// ----------------------------------------------------------------------------
// Bounded deque engine
// A push or pop result beat passes through the s1 register and the output register
// of the result stage; one push or pop can be accepted every cycle while the
// result stage can load. A dump reads stored words one by one via the single
// store read port; no command is accepted until its final word has been read.
// Reset clears the front pointer, the count and all valid flags; the store
// contents are not reset and are only read after being written.
// ----------------------------------------------------------------------------
`include "bounded_deque_engine_macros.svh"

module bounded_deque_engine import bde_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	bde_cmd_if.sink   cmd,
	bde_res_if.source res
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	bde_tag_t                     tag;
	logic [CW-1:0]                tag_count;
	logic                         load_ready;
	logic                         ram_we;
	logic [PW-1:0]                ram_waddr;
	logic signed [DATA_WIDTH-1:0] ram_wdata;
	logic                         ram_re;
	logic [PW-1:0]                ram_raddr;
	logic signed [DATA_WIDTH-1:0] ram_rdata;

	bde_ctrl #(
		.DEPTH(DEPTH),
		.DATA_WIDTH(DATA_WIDTH)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.load_ready(load_ready),
		.tag(tag),
		.tag_count(tag_count),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(ram_re),
		.raddr(ram_raddr)
	);

	bde_ram #(
		.DEPTH(DEPTH),
		.DATA_WIDTH(DATA_WIDTH)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	bde_outq #(
		.DEPTH(DEPTH),
		.DATA_WIDTH(DATA_WIDTH)
	) u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.tag(tag),
		.tag_count(tag_count),
		.rdata(ram_rdata),
		.load_ready(load_ready),
		.res(res)
	);

	`BDE_ASSERT_NEVER(a_no_read_write_clash, clk, arst_n, ram_we && ram_re)
	`BDE_ASSERT_IMPLY(a_accept_issues_beat, clk, arst_n, cmd.valid && cmd.ready, tag.valid)
	`BDE_ASSERT_IMPLY(a_read_has_beat, clk, arst_n, ram_re, tag.valid && tag.has_word && load_ready)

endmodule
